@@ hdl/kcr_pkg.sv @@
// kcr_pkg: shared codes, pass modes and controller/datapath link types
package kcr_pkg;

  // operation codes
  localparam logic [2:0] OP_PUT     = 3'd0;
  localparam logic [2:0] OP_GET     = 3'd1;
  localparam logic [2:0] OP_REMOVE  = 3'd2;
  localparam logic [2:0] OP_HAS     = 3'd3;
  localparam logic [2:0] OP_TOUCH   = 3'd4;
  localparam logic [2:0] OP_CLEANUP = 3'd5;

  // replacement policies (other codes act as fifo)
  localparam logic [1:0] POL_LRU = 2'd0;
  localparam logic [1:0] POL_LFU = 2'd1;

  // register indexes
  localparam logic [1:0] REG_POLICY   = 2'd0;
  localparam logic [1:0] REG_CAPACITY = 2'd1;
  localparam logic [1:0] REG_LIFE     = 2'd2;
  localparam logic [1:0] REG_PERIOD   = 2'd3;

  localparam logic [15:0] SWEEP_RESET = 16'd60;
  localparam logic [6:0]  CAP_RESET   = 7'd64;

  // one pass walks every table entry once
  typedef enum logic [2:0] {
    PM_SCAN   = 3'd0,
    PM_DROP   = 3'd1,
    PM_FRONT  = 3'd2,
    PM_LFU1   = 3'd3,
    PM_LFU2   = 3'd4,
    PM_SET    = 3'd5,
    PM_INSERT = 3'd6,
    PM_CLEAR  = 3'd7
  } pass_mode_t;

  // which tracked entry a pass acts on
  typedef enum logic [1:0] {
    TGT_HIT    = 2'd0,
    TGT_EXP    = 2'd1,
    TGT_VICTIM = 2'd2,
    TGT_SLOT   = 2'd3
  } tgt_t;

  typedef struct packed {
    logic       start;
    pass_mode_t mode;
    tgt_t       tgt;
    logic       capture;
    logic       cnt_hit;
    logic       cnt_miss;
    logic       mark_evict;
    logic       set_sweep;
    logic       set_ok;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic       done;
    logic       hit;
    logic       hit_expired;
    logic       exp_found;
    logic       victim_found;
    logic       free_found;
    logic       sweep_due;
    logic       full;
    logic [2:0] op;
    logic [1:0] policy;
    logic       out_busy;
  } dp_stat_t;

endpackage

@@ hdl/kcr_ram.sv @@
// kcr_ram: generic single write port ram with registered read
module kcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

@@ hdl/kcr_datapath.sv @@
// kcr_datapath: entry table, pass engine, trackers, counters and result register
module kcr_datapath #(
  parameter int ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  kcr_pkg::dp_cmd_t  cmd,
  output kcr_pkg::dp_stat_t stat,
  input  logic [2:0]        in_op,
  input  logic [63:0]       in_key,
  input  logic [63:0]       in_value,
  input  logic [31:0]       in_ttl,
  input  logic [31:0]       in_now,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_ok,
  output logic [63:0]       out_read_value,
  output logic              out_evicted,
  output logic [6:0]        out_entries_used,
  output logic [31:0]       out_hit_total,
  output logic [31:0]       out_miss_total,
  output logic [31:0]       out_evict_total
);
  localparam int IW = $clog2(ENTRIES);
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int CW = (UW > 7) ? UW : 7;
  localparam logic [IW-1:0] LAST     = IW'(ENTRIES - 1);
  localparam logic [UW-1:0] FULL_CAP = UW'(ENTRIES);

  typedef struct packed {
    logic          vld;
    logic [63:0]   key;
    logic [63:0]   val;
    logic [31:0]   exp;
    logic [31:0]   uses;
    logic [IW-1:0] rank;
  } rec_t;

  // configuration
  logic [1:0]  policy;
  logic [6:0]  capacity;
  logic [31:0] default_life;
  logic [15:0] period;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= kcr_pkg::POL_LRU;
      capacity     <= kcr_pkg::CAP_RESET;
      default_life <= '0;
      period       <= kcr_pkg::SWEEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kcr_pkg::REG_POLICY:   policy       <= cfg_data[1:0];
        kcr_pkg::REG_CAPACITY: capacity     <= cfg_data[6:0];
        kcr_pkg::REG_LIFE:     default_life <= cfg_data;
        kcr_pkg::REG_PERIOD:   period       <= cfg_data[15:0];
      endcase
    end
  end

  // latched item
  logic [2:0]  op_q;
  logic [63:0] key_q, val_q;
  logic [31:0] ttl_q, now_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= in_op;
      key_q <= in_key;
      val_q <= in_value;
      ttl_q <= in_ttl;
      now_q <= in_now;
    end
  end

  // expiry for put and touch, saturating
  logic [31:0] life, exp_new;
  logic [32:0] exp_sum;
  always_comb begin
    life    = (ttl_q != '0) ? ttl_q : default_life;
    exp_sum = {1'b0, now_q} + {1'b0, life};
    if (life == '0)      exp_new = '0;
    else if (exp_sum[32]) exp_new = '1;
    else                 exp_new = exp_sum[31:0];
  end

  // pass engine
  logic             running, stg_vld, done_q;
  logic [IW-1:0]    rd_addr, stg_addr;
  kcr_pkg::pass_mode_t mode_q;
  logic [IW-1:0]    tgt_idx, tgt_rank, p_rank;
  rec_t             rd, w;
  logic             wr;
  logic [UW-1:0]    used;

  kcr_ram #(.WIDTH($bits(rec_t)), .DEPTH(ENTRIES)) u_table (
    .clk   (clk),
    .we    (wr & stg_vld),
    .waddr (stg_addr),
    .wdata (w),
    .re    (running),
    .raddr (rd_addr),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      stg_vld <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stg_vld <= running;
      done_q  <= stg_vld && (stg_addr == LAST);
      if (cmd.start) begin
        running <= 1'b1;
      end else if (running && rd_addr == LAST) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    stg_addr <= rd_addr;
    if (cmd.start)    rd_addr <= '0;
    else if (running) rd_addr <= rd_addr + IW'(1);
  end

  // trackers
  logic          hit_f, free_f, tail_f, lv_f, exp_f;
  logic [IW-1:0] hit_idx, free_idx, tail_idx, tail_rank, lv_idx, lv_rank, exp_idx, exp_rank;
  logic [31:0]   lv_uses;
  rec_t          hit_rec, upd;
  logic          evicted_q, ok_q;

  logic          victim_f;
  logic [IW-1:0] victim_idx, victim_rank, slot_idx, sel_idx, sel_rank;

  always_comb begin
    if (policy == kcr_pkg::POL_LFU) begin
      victim_f    = lv_f;
      victim_idx  = lv_idx;
      victim_rank = lv_rank;
    end else begin
      victim_f    = tail_f;
      victim_idx  = tail_idx;
      victim_rank = tail_rank;
    end
    // lowest free slot once the victim is gone
    slot_idx = (evicted_q && (!free_f || victim_idx < free_idx)) ? victim_idx : free_idx;
    unique case (cmd.tgt)
      kcr_pkg::TGT_HIT:    begin sel_idx = hit_idx;    sel_rank = hit_rec.rank; end
      kcr_pkg::TGT_EXP:    begin sel_idx = exp_idx;    sel_rank = exp_rank;     end
      kcr_pkg::TGT_VICTIM: begin sel_idx = victim_idx; sel_rank = victim_rank;  end
      kcr_pkg::TGT_SLOT:   begin sel_idx = slot_idx;   sel_rank = '0;           end
    endcase
  end

  // hit entry after this item's update
  always_comb begin
    upd = hit_rec;
    if (op_q == kcr_pkg::OP_PUT) upd.val = val_q;
    if (op_q == kcr_pkg::OP_PUT || op_q == kcr_pkg::OP_TOUCH) upd.exp = exp_new;
    if ((op_q == kcr_pkg::OP_PUT || op_q == kcr_pkg::OP_GET) && hit_rec.uses != '1)
      upd.uses = hit_rec.uses + 32'd1;
  end

  logic is_t, rd_exp;
  assign is_t   = (stg_addr == tgt_idx);
  assign rd_exp = (rd.exp != '0) && (rd.exp <= now_q);

  // per-entry rewrite
  always_comb begin
    w  = rd;
    wr = 1'b1;
    unique case (mode_q)
      kcr_pkg::PM_SCAN: wr = 1'b0;
      kcr_pkg::PM_DROP: begin
        if (is_t) w.vld = 1'b0;
        else if (rd.vld && rd.rank > tgt_rank) w.rank = rd.rank - IW'(1);
      end
      kcr_pkg::PM_FRONT: begin
        if (is_t) begin
          w      = upd;
          w.rank = '0;
        end else if (rd.vld && rd.rank < tgt_rank) begin
          w.rank = rd.rank + IW'(1);
        end
      end
      kcr_pkg::PM_LFU1: begin
        if (is_t) w = upd;
        else if (rd.vld && rd.rank > tgt_rank) w.rank = rd.rank - IW'(1);
      end
      kcr_pkg::PM_LFU2: begin
        if (is_t) w.rank = p_rank;
        else if (rd.vld && rd.rank >= p_rank) w.rank = rd.rank + IW'(1);
      end
      kcr_pkg::PM_SET: begin
        wr = is_t;
        if (is_t) w = upd;
      end
      kcr_pkg::PM_INSERT: begin
        if (is_t) begin
          w.vld  = 1'b1;
          w.key  = key_q;
          w.val  = val_q;
          w.exp  = exp_new;
          w.uses = 32'd1;
          w.rank = '0;
        end else if (rd.vld) begin
          w.rank = rd.rank + IW'(1);
        end
      end
      kcr_pkg::PM_CLEAR: w.vld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_q   <= cmd.mode;
      tgt_idx  <= sel_idx;
      tgt_rank <= sel_rank;
      // the lfu insert point found by the first lfu pass is kept for the second
      if (cmd.mode != kcr_pkg::PM_LFU2) p_rank <= IW'(used - UW'(1));
      if (cmd.mode == kcr_pkg::PM_SCAN) begin
        hit_f  <= 1'b0;
        free_f <= 1'b0;
        tail_f <= 1'b0;
        lv_f   <= 1'b0;
      end
      if (cmd.mode == kcr_pkg::PM_SCAN || cmd.mode == kcr_pkg::PM_DROP) exp_f <= 1'b0;
    end else if (stg_vld) begin
      if (mode_q == kcr_pkg::PM_SCAN) begin
        if (rd.vld && rd.key == key_q && !hit_f) begin
          hit_f   <= 1'b1;
          hit_idx <= stg_addr;
          hit_rec <= rd;
        end
        if (!rd.vld && !free_f) begin
          free_f   <= 1'b1;
          free_idx <= stg_addr;
        end
        if (rd.vld && rd.rank == IW'(used - UW'(1))) begin
          tail_f    <= 1'b1;
          tail_idx  <= stg_addr;
          tail_rank <= rd.rank;
        end
        // least used, nearest the front on a tie
        if (rd.vld && (!lv_f || rd.uses < lv_uses ||
                       (rd.uses == lv_uses && rd.rank < lv_rank))) begin
          lv_f    <= 1'b1;
          lv_idx  <= stg_addr;
          lv_uses <= rd.uses;
          lv_rank <= rd.rank;
        end
      end
      // next expired entry, rank as left by this pass
      if ((mode_q == kcr_pkg::PM_SCAN || (mode_q == kcr_pkg::PM_DROP && !is_t)) &&
          rd.vld && rd_exp && !exp_f) begin
        exp_f    <= 1'b1;
        exp_idx  <= stg_addr;
        exp_rank <= w.rank;
      end
      if (mode_q == kcr_pkg::PM_LFU1 && !is_t && rd.vld && rd.uses < upd.uses &&
          w.rank < p_rank) begin
        p_rank <= w.rank;
      end
    end
  end

  // occupancy, counters and flags
  logic [31:0] hit_cnt, miss_cnt, evict_cnt, last_sweep;

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      hit_cnt    <= '0;
      miss_cnt   <= '0;
      evict_cnt  <= '0;
      last_sweep <= '0;
      ok_q       <= 1'b0;
      evicted_q  <= 1'b0;
    end else begin
      if (stg_vld && stg_addr == LAST) begin
        if (mode_q == kcr_pkg::PM_DROP && used != '0) used <= used - UW'(1);
        if (mode_q == kcr_pkg::PM_INSERT)             used <= used + UW'(1);
      end
      if (cmd.capture) begin
        ok_q      <= 1'b0;
        evicted_q <= 1'b0;
      end
      if (cmd.set_ok) ok_q <= 1'b1;
      if (cmd.cnt_hit && hit_cnt != '1)   hit_cnt  <= hit_cnt + 32'd1;
      if (cmd.cnt_miss && miss_cnt != '1) miss_cnt <= miss_cnt + 32'd1;
      if (cmd.mark_evict) begin
        evicted_q <= 1'b1;
        if (evict_cnt != '1) evict_cnt <= evict_cnt + 32'd1;
      end
      if (cmd.set_sweep) last_sweep <= now_q;
    end
  end

  logic [UW-1:0] eff_cap;
  always_comb begin
    if (capacity == '0 || CW'(capacity) > CW'(ENTRIES)) eff_cap = FULL_CAP;
    else                                               eff_cap = UW'(capacity);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ok           <= ok_q;
      out_read_value   <= (op_q == kcr_pkg::OP_GET && ok_q) ? hit_rec.val : '0;
      out_evicted      <= evicted_q;
      out_entries_used <= 7'(used);
      out_hit_total    <= hit_cnt;
      out_miss_total   <= miss_cnt;
      out_evict_total  <= evict_cnt;
    end
  end

  always_comb begin
    stat.done         = done_q;
    stat.hit          = hit_f;
    stat.hit_expired  = (hit_rec.exp != '0) && (hit_rec.exp <= now_q);
    stat.exp_found    = exp_f;
    stat.victim_found = victim_f;
    stat.free_found   = free_f;
    stat.sweep_due    = (now_q >= last_sweep) && ((now_q - last_sweep) >= {16'd0, period});
    stat.full         = used >= eff_cap;
    stat.op           = op_q;
    stat.policy       = policy;
    stat.out_busy     = out_valid && !out_ready;
  end
endmodule

@@ hdl/kcr_ctrl.sv @@
// kcr_ctrl: sequencer that orders the table passes for each operation
module kcr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  kcr_pkg::dp_stat_t stat,
  output kcr_pkg::dp_cmd_t  cmd,
  input  logic              in_valid,
  output logic              in_ready
);
  typedef enum logic [9:0] {
    S_RST    = 10'b00_0000_0001,
    S_CLEAR  = 10'b00_0000_0010,
    S_IDLE   = 10'b00_0000_0100,
    S_SCAN   = 10'b00_0000_1000,
    S_SWEEP  = 10'b00_0001_0000,
    S_RESCAN = 10'b00_0010_0000,
    S_EVICT  = 10'b00_0100_0000,
    S_LFU1   = 10'b00_1000_0000,
    S_WAIT   = 10'b01_0000_0000,
    S_RESP   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  kcr_pkg::pass_mode_t reorder_mode;
  state_t reorder_state;

  always_ff @(posedge clk) begin
    if (rst) state <= S_RST;
    else     state <= state_next;
  end

  always_comb begin
    if (stat.policy == kcr_pkg::POL_LRU) begin
      reorder_mode  = kcr_pkg::PM_FRONT;
      reorder_state = S_WAIT;
    end else if (stat.policy == kcr_pkg::POL_LFU) begin
      reorder_mode  = kcr_pkg::PM_LFU1;
      reorder_state = S_LFU1;
    end else begin
      reorder_mode  = kcr_pkg::PM_SET;
      reorder_state = S_WAIT;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_RST: begin
        cmd.start  = 1'b1;
        cmd.mode   = kcr_pkg::PM_CLEAR;
        state_next = S_CLEAR;
      end
      S_CLEAR: if (stat.done) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.start   = 1'b1;
          cmd.mode    = kcr_pkg::PM_SCAN;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.done) begin
          state_next = S_RESP;
          unique case (stat.op)
            kcr_pkg::OP_PUT: begin
              cmd.set_ok = 1'b1;
              if (stat.hit) begin
                cmd.start  = 1'b1;
                cmd.mode   = reorder_mode;
                cmd.tgt    = kcr_pkg::TGT_HIT;
                state_next = reorder_state;
              end else if (stat.sweep_due && stat.exp_found) begin
                cmd.set_sweep = 1'b1;
                cmd.start     = 1'b1;
                cmd.mode      = kcr_pkg::PM_DROP;
                cmd.tgt       = kcr_pkg::TGT_EXP;
                state_next    = S_SWEEP;
              end else begin
                cmd.set_sweep = stat.sweep_due;
                if (stat.full && stat.victim_found) begin
                  cmd.mark_evict = 1'b1;
                  cmd.start      = 1'b1;
                  cmd.mode       = kcr_pkg::PM_DROP;
                  cmd.tgt        = kcr_pkg::TGT_VICTIM;
                  state_next     = S_EVICT;
                end else if (stat.free_found) begin
                  cmd.start  = 1'b1;
                  cmd.mode   = kcr_pkg::PM_INSERT;
                  cmd.tgt    = kcr_pkg::TGT_SLOT;
                  state_next = S_WAIT;
                end
              end
            end
            kcr_pkg::OP_GET: begin
              if (!stat.hit) begin
                cmd.cnt_miss = 1'b1;
              end else if (stat.hit_expired) begin
                cmd.cnt_miss = 1'b1;
                cmd.start    = 1'b1;
                cmd.mode     = kcr_pkg::PM_DROP;
                cmd.tgt      = kcr_pkg::TGT_HIT;
                state_next   = S_WAIT;
              end else begin
                cmd.cnt_hit = 1'b1;
                cmd.set_ok  = 1'b1;
                cmd.start   = 1'b1;
                cmd.mode    = reorder_mode;
                cmd.tgt     = kcr_pkg::TGT_HIT;
                state_next  = reorder_state;
              end
            end
            kcr_pkg::OP_REMOVE: begin
              if (stat.hit) begin
                cmd.set_ok = 1'b1;
                cmd.start  = 1'b1;
                cmd.mode   = kcr_pkg::PM_DROP;
                cmd.tgt    = kcr_pkg::TGT_HIT;
                state_next = S_WAIT;
              end
            end
            kcr_pkg::OP_HAS: cmd.set_ok = stat.hit && !stat.hit_expired;
            kcr_pkg::OP_TOUCH: begin
              if (stat.hit) begin
                cmd.set_ok = 1'b1;
                cmd.start  = 1'b1;
                cmd.mode   = kcr_pkg::PM_SET;
                cmd.tgt    = kcr_pkg::TGT_HIT;
                state_next = S_WAIT;
              end
            end
            kcr_pkg::OP_CLEANUP: begin
              cmd.set_ok    = 1'b1;
              cmd.set_sweep = 1'b1;
              if (stat.exp_found) begin
                cmd.start  = 1'b1;
                cmd.mode   = kcr_pkg::PM_DROP;
                cmd.tgt    = kcr_pkg::TGT_EXP;
                state_next = S_SWEEP;
              end
            end
            default: state_next = S_RESP;
          endcase
        end
      end
      S_SWEEP: begin
        if (stat.done) begin
          if (stat.exp_found) begin
            cmd.start = 1'b1;
            cmd.mode  = kcr_pkg::PM_DROP;
            cmd.tgt   = kcr_pkg::TGT_EXP;
          end else if (stat.op == kcr_pkg::OP_PUT) begin
            cmd.start  = 1'b1;
            cmd.mode   = kcr_pkg::PM_SCAN;
            state_next = S_RESCAN;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_RESCAN: begin
        if (stat.done) begin
          if (stat.full && stat.victim_found) begin
            cmd.mark_evict = 1'b1;
            cmd.start      = 1'b1;
            cmd.mode       = kcr_pkg::PM_DROP;
            cmd.tgt        = kcr_pkg::TGT_VICTIM;
            state_next     = S_EVICT;
          end else if (stat.free_found) begin
            cmd.start  = 1'b1;
            cmd.mode   = kcr_pkg::PM_INSERT;
            cmd.tgt    = kcr_pkg::TGT_SLOT;
            state_next = S_WAIT;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_EVICT: begin
        if (stat.done) begin
          cmd.start  = 1'b1;
          cmd.mode   = kcr_pkg::PM_INSERT;
          cmd.tgt    = kcr_pkg::TGT_SLOT;
          state_next = S_WAIT;
        end
      end
      S_LFU1: begin
        if (stat.done) begin
          cmd.start  = 1'b1;
          cmd.mode   = kcr_pkg::PM_LFU2;
          cmd.tgt    = kcr_pkg::TGT_HIT;
          state_next = S_WAIT;
        end
      end
      S_WAIT: if (stat.done) state_next = S_RESP;
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_RST;
    endcase
  end
endmodule

@@ hdl/keyed_cache_with_replacement_policy_unit.sv @@
// keyed_cache_with_replacement_policy_unit: keyed cache with lru, lfu and fifo replacement
//
//   channel   direction  handshake                   payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  s_axis_tdata: op key value ttl now
//   m_axis    out        m_axis_tvalid/m_axis_tready  m_axis_tdata: ok read_value evicted
//                                                     entries_used hit/miss/evict totals
//   cfg       in         cfg_we                       cfg_index, cfg_data
//
// one word at a time; every step is a pass over the entry ram, one entry per cycle
// (the single read port of the entry ram sets this rate)
// has and misses of absent keys: one pass; get/put hit: two or three; put of a new key: two or three,
// plus a rescan and one pass per entry dropped when an expiry sweep drops anything
// after reset a clearing pass runs before the first word is taken
// a finished result waits in the output register while the next word is taken
module keyed_cache_with_replacement_policy_unit #(
  parameter int ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [199:0] s_axis_tdata,   // op[2:0] key[66:3] value[130:67] ttl[162:131] now[194:163]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [175:0] m_axis_tdata,   // ok[0] read_value[64:1] evicted[65] entries_used[72:66]
                                       // hit_total[104:73] miss_total[136:105]
                                       // evict_total[168:137]
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  kcr_pkg::dp_cmd_t  cmd;
  kcr_pkg::dp_stat_t stat;

  logic        ok, evicted;
  logic [63:0] read_value;
  logic [6:0]  entries_used;
  logic [31:0] hit_total, miss_total, evict_total;

  // sequencer
  kcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .cmd      (cmd),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready)
  );

  // entry table and everything it feeds
  kcr_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (s_axis_tdata[2:0]),
    .in_key           (s_axis_tdata[66:3]),
    .in_value         (s_axis_tdata[130:67]),
    .in_ttl           (s_axis_tdata[162:131]),
    .in_now           (s_axis_tdata[194:163]),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_ok           (ok),
    .out_read_value   (read_value),
    .out_evicted      (evicted),
    .out_entries_used (entries_used),
    .out_hit_total    (hit_total),
    .out_miss_total   (miss_total),
    .out_evict_total  (evict_total)
  );

  // pack the result word, zero fill to whole bytes
  assign m_axis_tdata = {7'd0, evict_total, miss_total, hit_total, entries_used,
                         evicted, read_value, ok};
endmodule

@@ hdl/kcr_checker.sv @@
// kcr_checker: port level checks for the keyed cache, bound to the top level
module kcr_checker #(
  parameter int ENTRIES = 64
) (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [175:0] m_axis_tdata
);
  // result waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped before it was taken");

  // one word in flight: input closes right after a word is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while one is in work");

  // occupancy never above table size
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (ENTRIES > 127) || (m_axis_tdata[72:66] <= 7'(ENTRIES)))
    else $error("entries_used above table size");

  // read_value only on a successful get
  a_rv_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[64:1] == 64'd0)
    else $error("read_value set without ok");

  // eviction only from a put, which always succeeds
  a_evict_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[65] |-> m_axis_tdata[0])
    else $error("evicted without ok");
endmodule

bind keyed_cache_with_replacement_policy_unit kcr_checker #(.ENTRIES(ENTRIES)) u_kcr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
